@@ hw/rtl/sha512_pkg.sv @@
// Shared types, constants and functions for the SHA-512 block compression core.
`default_nettype none

package sha512_pkg;

    typedef logic [63:0] word_t;

    // Round and block sizes
    localparam int NUM_ROUNDS  = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 8;

    // Initial hash set codes
    localparam logic [1:0] VAR_SHA512     = 2'd0;
    localparam logic [1:0] VAR_SHA512_224 = 2'd1;
    localparam logic [1:0] VAR_SHA512_256 = 2'd2;

    // Control from the sequencer to the datapath units
    typedef struct packed {
        logic load;    // copy chained hash into the working variables
        logic step;    // run one round / advance the schedule
    } round_ctrl_t;

    localparam word_t IV_512 [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam word_t IV_224 [0:7] = '{
        64'h8C3D37C819544DA2, 64'h73E1996689DCD4D6, 64'h1DFAB7AE32FF9C82, 64'h679DD514582F9FCF,
        64'h0F6D2B697BD44DA8, 64'h77E36F7304C48942, 64'h3F9D85A86A1D36C8, 64'h1112E6AD91D692A1
    };

    localparam word_t IV_256 [0:7] = '{
        64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151, 64'h963877195940EABD,
        64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992, 64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
    };

    localparam word_t ROUND_K [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // Initial hash word; the unused variant code falls back to plain SHA-512
    function automatic word_t iv_word(input logic [1:0] var_sel, input logic [2:0] idx);
        word_t w;
        case (var_sel)
            VAR_SHA512_224: w = IV_224[idx];
            VAR_SHA512_256: w = IV_256[idx];
            default:        w = IV_512[idx];
        endcase
        return w;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha512_sched.sv @@
// Message schedule: sixteen-word shift line that expands the block one word per round.
`default_nettype none

module sha512_sched (
    input  wire                       aclk,
    input  wire                       word_we,
    input  sha512_pkg::word_t         word_in,
    input  sha512_pkg::round_ctrl_t   ctrl,
    output sha512_pkg::word_t         w_round
);
    import sha512_pkg::*;

    word_t w_reg  [BLOCK_WORDS];
    word_t w_next [BLOCK_WORDS];
    word_t w_new;

    // Next schedule word from the fixed taps
    assign w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);

    // Shift in either a message word or an expanded word
    always_comb begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            w_next[i] = w_reg[i + 1];
        end
        w_next[BLOCK_WORDS - 1] = word_we ? word_in : w_new;
    end

    always_ff @(posedge aclk) begin
        if (word_we || ctrl.step) begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                w_reg[i] <= w_next[i];
            end
        end
    end

    assign w_round = w_reg[0];

endmodule

`default_nettype wire

@@ hw/rtl/sha512_round.sv @@
// Shared round unit: working variables a..h and one SHA-512 round per cycle.
`default_nettype none

module sha512_round (
    input  wire                       aclk,
    input  sha512_pkg::round_ctrl_t   ctrl,
    input  sha512_pkg::word_t         chain_hash [8],
    input  sha512_pkg::word_t         k_round,
    input  sha512_pkg::word_t         w_round,
    output sha512_pkg::word_t         work_vars [8]
);
    import sha512_pkg::*;

    word_t v_reg [HASH_WORDS];
    word_t t1;
    word_t t2;

    // Round sums
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + k_round + w_round;
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // Load from the chained hash, or rotate the variables through one round
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                v_reg[i] <= chain_hash[i];
            end
        end else if (ctrl.step) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_comb begin
        for (int i = 0; i < HASH_WORDS; i++) begin
            work_vars[i] = v_reg[i];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sha512_block_compression.sv @@
// Top level of the SHA-512 block compression core: sequencer, chained hash and digest output.
//
// Usage: message words enter on the s_ channel, one 64-bit big-endian word per beat,
// sixteen beats per 1024-bit block, already padded. s_tuser marks the first word of a
// message and reloads the initial hash chosen by cfg_wdata (0 SHA-512, 1 SHA-512/224,
// 2 SHA-512/256); s_tlast on the sixteenth word marks the final block.
// Word beats are taken back to back while the block is idle. After the sixteenth beat
// the block runs 80 rounds of the shared round unit, one round per cycle, then an add
// into the chained hash; s_tready stays low through all the rounds and the add step.
// After a final block the eight hash words leave on the m_ channel from an output
// buffer, H0 first, with m_tuser the word index and m_tlast on H7. The first digest
// beat is offered straight after the add cycle. The input side keeps taking words
// while the digest drains; a following final block waits in its add cycle until the
// buffer has emptied. A stall on m_tready holds the current beat unchanged.
// Reset (aresetn low, synchronous) loads the SHA-512 initial hash, clears the word count
// and drops any pending digest. The user must write the variant register with cfg_wen
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module sha512_block_compression (
    input  wire         aclk,
    input  wire         aresetn,
    // Variant register
    input  wire         cfg_wen,
    input  wire  [1:0]  cfg_wdata,
    // Message words
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,     // [63:0] msg_word
    input  wire         s_tuser,     // [0] start_message
    input  wire         s_tlast,     // last_block
    // Digest words
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,     // [63:0] digest_word
    output logic [2:0]  m_tuser,     // [2:0] word_index
    output logic        m_tlast      // last_word
);
    import sha512_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [6:0]  round_reg, round_next;
    logic [3:0]  count_reg, count_next;
    logic [1:0]  variant_reg;
    logic        last_reg;
    word_t       chain_reg [HASH_WORDS];
    word_t       sum_hash  [HASH_WORDS];
    word_t       work_vars [HASH_WORDS];
    word_t       out_buf_reg [HASH_WORDS];
    logic        out_valid_reg;
    logic [2:0]  out_idx_reg;
    word_t       w_round;
    word_t       k_round;
    round_ctrl_t ctrl;
    logic        in_beat;
    logic        out_beat;
    logic        block_done;
    logic        add_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = out_valid_reg && m_tready;

    // Word count restarts on the first word of a message
    assign count_next = s_tuser ? 4'd1 : count_reg + 4'd1;
    assign block_done = in_beat && (count_next == 4'd0);

    // Final add waits for the digest buffer to drain when it has to refill it
    assign add_go = (state_reg == ST_ADD) && !(last_reg && out_valid_reg);

    assign ctrl.load = block_done;
    assign ctrl.step = (state_reg == ST_ROUND);
    assign k_round   = ROUND_K[round_reg];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (block_done) begin
                    state_next = ST_ROUND;
                    round_next = 7'd0;
                end
            end
            ST_ROUND: begin
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(NUM_ROUNDS - 1)) begin
                    state_next = ST_ADD;
                    round_next = 7'd0;
                end
            end
            ST_ADD: begin
                if (add_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            round_reg   <= 7'd0;
            count_reg   <= 4'd0;
            variant_reg <= VAR_SHA512;
            last_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            if (in_beat) begin
                count_reg <= count_next;
            end
            if (block_done) begin
                last_reg <= s_tlast;
            end
            if (cfg_wen) begin
                variant_reg <= cfg_wdata;
            end
        end
    end

    // Chained hash: reload on message start, accumulate after each block
    always_comb begin
        for (int i = 0; i < HASH_WORDS; i++) begin
            sum_hash[i] = chain_reg[i] + work_vars[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                chain_reg[i] <= IV_512[i];
            end
        end else if (in_beat && s_tuser) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                chain_reg[i] <= iv_word(variant_reg, 3'(i));
            end
        end else if (add_go) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                chain_reg[i] <= sum_hash[i];
            end
        end
    end

    // Digest buffer: load after a final block, shift one word per beat
    always_ff @(posedge aclk) begin
        if (add_go && last_reg) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                out_buf_reg[i] <= sum_hash[i];
            end
        end else if (out_beat) begin
            for (int i = 0; i < HASH_WORDS - 1; i++) begin
                out_buf_reg[i] <= out_buf_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 3'd0;
        end else if (add_go && last_reg) begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= 3'd0;
        end else if (out_beat) begin
            out_idx_reg <= out_idx_reg + 3'd1;
            if (out_idx_reg == 3'(HASH_WORDS - 1)) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_buf_reg[0];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == 3'(HASH_WORDS - 1));

    sha512_sched u_sched (
        .aclk    (aclk),
        .word_we (in_beat),
        .word_in (s_tdata),
        .ctrl    (ctrl),
        .w_round (w_round)
    );

    sha512_round u_round (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .chain_hash (chain_reg),
        .k_round    (k_round),
        .w_round    (w_round),
        .work_vars  (work_vars)
    );

endmodule

`default_nettype wire

@@ hw/rtl/sha512_checker.sv @@
// Port-level checker for the SHA-512 block compression core, bound to the top level.
`default_nettype none

module sha512_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [63:0] m_tdata,
    input wire [2:0]  m_tuser,
    input wire        m_tlast
);

    // Hold a stalled digest beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("digest beat changed while stalled");

    // A digest always starts at H0
    a_out_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> m_tuser == 3'd0)
        else $error("digest did not start at word 0");

    // Word index advances by one inside a digest
    a_out_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == 3'($past(m_tuser) + 3'd1))
        else $error("digest word index skipped");

    // Last flag only on H7
    a_out_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("last flag off the eighth word");

endmodule

bind sha512_block_compression sha512_checker u_sha512_checker (.*);

`default_nettype wire

@@ tb/sv/tb_sha512_block_compression.sv @@
// Testbench for the SHA-512 block compression core: stimulus, digest prediction and checks.
`timescale 1ns / 100ps

package sha512_digest_check_pkg;

    import sha512_pkg::word_t;
    import sha512_pkg::VAR_SHA512_224;
    import sha512_pkg::VAR_SHA512_256;

    // Code outside the defined initial hash sets
    localparam logic [1:0] VAR_SPARE = 2'd3;

    localparam word_t START_HASH_512 [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam word_t START_HASH_224 [0:7] = '{
        64'h8C3D37C819544DA2, 64'h73E1996689DCD4D6, 64'h1DFAB7AE32FF9C82, 64'h679DD514582F9FCF,
        64'h0F6D2B697BD44DA8, 64'h77E36F7304C48942, 64'h3F9D85A86A1D36C8, 64'h1112E6AD91D692A1
    };

    localparam word_t START_HASH_256 [0:7] = '{
        64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151, 64'h963877195940EABD,
        64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992, 64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
    };

    localparam word_t RND_CONST [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // One expected beat of a digest
    typedef struct packed {
        word_t      hash;
        logic [2:0] pos;
        logic       is_last;
    } digest_beat_t;

    function automatic word_t rot_right(input word_t x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Tracks the chained hash and the words of the open block, predicts every digest
    class sha512_digest_board;
        word_t        chain [8];
        word_t        block_buf [16];
        int unsigned  fill;
        logic [1:0]   variant;
        digest_beat_t digests_due [$];
        int unsigned  mismatches;
        int unsigned  blocks_done;
        int unsigned  digests_made;
        int unsigned  beats_checked;
        int unsigned  restarts;

        function new();
            variant = 2'd0;
            fill = 0;
            foreach (block_buf[i]) block_buf[i] = '0;
            load_start_hash();
        endfunction

        function void load_start_hash();
            for (int i = 0; i < 8; i++) begin
                case (variant)
                    VAR_SHA512_224: chain[i] = START_HASH_224[i];
                    VAR_SHA512_256: chain[i] = START_HASH_256[i];
                    default:        chain[i] = START_HASH_512[i];
                endcase
            end
        endfunction

        function void set_variant(input logic [1:0] v);
            variant = v;
        endfunction

        // Run the 80 rounds on the full block and fold the result into the chain
        function void compress_block();
            word_t sched [16];
            word_t v [8];
            word_t wr, x, y, t1, t2, s0, s1;
            for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int r = 0; r < 80; r++) begin
                if (r < 16) begin
                    wr = sched[r];
                end else begin
                    x  = sched[(r - 15) % 16];
                    y  = sched[(r - 2) % 16];
                    s0 = rot_right(x, 1) ^ rot_right(x, 8) ^ (x >> 7);
                    s1 = rot_right(y, 19) ^ rot_right(y, 61) ^ (y >> 6);
                    wr = sched[r % 16] + s0 + sched[(r - 7) % 16] + s1;
                    sched[r % 16] = wr;
                end
                t1 = v[7] + (rot_right(v[4], 14) ^ rot_right(v[4], 18) ^ rot_right(v[4], 41))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_CONST[r] + wr;
                t2 = (rot_right(v[0], 28) ^ rot_right(v[0], 34) ^ rot_right(v[0], 39))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        // Note one accepted message word
        function void take_word(input word_t w, input bit start, input bit final_blk);
            digest_beat_t b;
            if (start) begin
                if (fill != 0) restarts++;
                load_start_hash();
                fill = 0;
            end
            block_buf[fill] = w;
            fill = (fill + 1) % 16;
            if (fill != 0) return;
            compress_block();
            blocks_done++;
            if (!final_blk) return;
            for (int k = 0; k < 8; k++) begin
                b.hash    = chain[k];
                b.pos     = 3'(k);
                b.is_last = (k == 7);
                digests_due.push_back(b);
            end
            digests_made++;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        // Compare one accepted digest beat with the oldest one due
        task check_digest_beat(input word_t hash, input logic [2:0] pos, input logic is_last);
            digest_beat_t e;
            if (digests_due.size() == 0) begin
                report_mismatch($sformatf("digest beat %h with none due", hash));
                return;
            end
            e = digests_due.pop_front();
            beats_checked++;
            if (hash !== e.hash)
                report_mismatch($sformatf("H%0d got %h want %h", e.pos, hash, e.hash));
            if (pos !== e.pos)
                report_mismatch($sformatf("word index got %0d want %0d", pos, e.pos));
            if (is_last !== e.is_last)
                report_mismatch($sformatf("last flag on H%0d got %b want %b",
                                          e.pos, is_last, e.is_last));
        endtask
    endclass

endpackage

module tb_sha512_block_compression;

    import sha512_pkg::word_t;
    import sha512_pkg::VAR_SHA512;
    import sha512_pkg::VAR_SHA512_224;
    import sha512_pkg::VAR_SHA512_256;
    import sha512_digest_check_pkg::*;

    localparam int RANDOM_WORDS = 330;
    localparam int PHASES       = 6;
    localparam int SETTLE       = 100;  // 80 rounds, add cycle and output start, with margin
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_PCT     = 12;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sha512_digest_board board = new();

    bit          calm        = 1'b0;
    bit          hold_req    = 1'b0;
    bit          force_start = 1'b0;
    int unsigned words_sent  = 0;
    int unsigned hold_left   = 0;

    logic [1:0] phase_variant [PHASES] = '{VAR_SHA512_224, VAR_SHA512_256, VAR_SPARE,
                                           VAR_SHA512, VAR_SHA512_256, VAR_SHA512_224};

    sha512_block_compression DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Pick a message word: extremes, single set or cleared bits and plain random values
    function automatic word_t rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(63);
            3:       return ~(word_t'(1) << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word beat and hold it until accepted; enters and leaves on a falling edge
    task automatic push_word(input word_t w, input bit tag_start, input bit tag_last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= tag_start;
        s_tlast  <= tag_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_word(w, tag_start, tag_last);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_block(input bit start, input bit final_blk);
        for (int i = 0; i < 16; i++)
            push_word(rand_word(), (i == 0) && start,
                      (i == 15) ? final_blk : bit'($urandom_range(1)));
    endtask

    // One message: mostly well formed, sometimes cut short or left without a final block
    task automatic send_message(input bit squeeze);
        int unsigned pick;
        int unsigned nblk;
        bit          start;
        pick  = $urandom_range(99);
        start = force_start || ($urandom_range(9) != 0);
        force_start = 1'b0;
        if (!squeeze && pick < 8) begin
            // drop a partial block; the next message restarts in mid-block
            nblk = $urandom_range(1, 15);
            for (int i = 0; i < nblk; i++)
                push_word(rand_word(), (i == 0) && start, bit'($urandom_range(1)));
            force_start = 1'b1;
        end else if (!squeeze && pick < 18) begin
            send_block(start, 1'b0);
        end else begin
            nblk = (squeeze || $urandom_range(3) != 0) ? 1 : $urandom_range(2, 3);
            for (int b = 0; b < nblk; b++)
                send_block((b == 0) && start, b == nblk - 1);
        end
    endtask

    // Hold the input idle until every digest is out and the core has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.digests_due.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_variant(input logic [1:0] v);
        cfg_wdata <= v;
        cfg_wen   <= 1'b1;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        board.set_variant(v);
    endtask

    // Receiver: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Check every accepted digest beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_digest_beat(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        #2_000_000;
        $display("run timed out with %0d digest beats due", board.digests_due.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned phase_base;
        int unsigned waited;
        word_t       pattern;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_variant(VAR_SHA512);

        // Directed: a dropped partial block, then a block of extreme words as the final one
        for (int i = 0; i < 4; i++)
            push_word('0, i == 0, 1'b1);
        for (int i = 0; i < 16; i++) begin
            case (i % 4)
                0:       pattern = '0;
                1:       pattern = '1;
                2:       pattern = 64'h8000_0000_0000_0001;
                default: pattern = 64'h5555_5555_aaaa_aaaa;
            endcase
            push_word(pattern, i == 0, (i == 15) || (i == 7));
        end
        drain();

        // Random phases, one variant each; the second squeezes the output, the fourth runs calm
        for (int p = 0; p < PHASES; p++) begin
            write_variant(phase_variant[p]);
            calm = (p == 3);
            if (p == 1) hold_req = 1'b1;
            phase_base = words_sent;
            while (words_sent - phase_base < RANDOM_WORDS / PHASES)
                send_message(p == 1);
            drain();
        end
        calm = 1'b0;

        // Wait out any stragglers, then settle
        waited = 0;
        while (board.digests_due.size() != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE) @(negedge aclk);
        if (board.digests_due.size() != 0)
            board.report_mismatch($sformatf("%0d digest beats never arrived",
                                            board.digests_due.size()));

        $display("covered %0d message words, %0d blocks compressed, %0d mid-block restarts",
                 words_sent, board.blocks_done, board.restarts);
        $display("checked %0d digests (%0d hash words) over all four variant codes",
                 board.digests_made, board.beats_checked);
        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_sched.sv
hw/rtl/sha512_round.sv
hw/rtl/sha512_block_compression.sv
hw/rtl/sha512_checker.sv
tb/sv/tb_sha512_block_compression.sv
